// ===== hw/rtl/pfa_pkg.sv =====
package pfa_pkg;

   typedef enum logic [1:0] {
      STRAT_FIRST = 2'd0,
      STRAT_BEST  = 2'd1,
      STRAT_WORST = 2'd2,
      STRAT_NEXT  = 2'd3
   } strategy_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   typedef struct packed {
      logic valid;
      logic found;
   } token_ctl_type;

   typedef struct packed {
      logic en;
      logic used;
   } wr_ctl_type;

endpackage

// ===== hw/rtl/pfa_cell.sv =====
module pfa_cell #(
   parameter int IW = 3,
   parameter int SW = 16,
   parameter int MY = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pfa_pkg::strategy_type  strategy,
   input  logic [IW-1:0]          start,
   input  logic [SW-1:0]          req,
   input  pfa_pkg::token_ctl_type tok_in_ctl,
   input  logic [IW-1:0]          tok_in_idx,
   input  logic [SW-1:0]          tok_in_left,
   input  logic [SW-1:0]          tok_in_held,
   input  pfa_pkg::wr_ctl_type    wr_ctl,
   input  logic [IW-1:0]          wr_idx,
   input  logic [SW-1:0]          wr_free,
   input  logic [SW-1:0]          wr_held,
   output pfa_pkg::token_ctl_type tok_out_ctl,
   output logic [IW-1:0]          tok_out_idx,
   output logic [SW-1:0]          tok_out_left,
   output logic [SW-1:0]          tok_out_held
);

   localparam logic [IW-1:0] MY_IDX = IW'(MY);

   logic [SW-1:0]          free_ff;
   logic [SW-1:0]          held_ff;
   logic                   used_ff;
   pfa_pkg::token_ctl_type tok_ctl_ff;
   pfa_pkg::token_ctl_type tok_ctl_in;
   logic [IW-1:0]          tok_idx_ff;
   logic [SW-1:0]          tok_left_ff;
   logic [SW-1:0]          tok_held_ff;
   logic                   fits;
   logic                   take;
   logic [SW-1:0]          left;

   // A cell takes the word if it fits and beats, or in worst fit ties, the pick so far.
   always_comb begin
      fits = (MY_IDX >= start) && (free_ff >= req);
      left = free_ff - req;
      take = 1'b0;
      unique case (strategy) inside
         pfa_pkg::STRAT_FIRST, pfa_pkg::STRAT_NEXT: take = fits && !tok_in_ctl.found;
         pfa_pkg::STRAT_BEST:  take = fits && (!tok_in_ctl.found || (left < tok_in_left));
         pfa_pkg::STRAT_WORST: take = fits && (!tok_in_ctl.found || (left >= tok_in_left));
         default: take = 1'b0;
      endcase
      tok_ctl_in.valid = tok_in_ctl.valid;
      tok_ctl_in.found = tok_in_ctl.valid && (tok_in_ctl.found || take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ctl_ff <= '0;
         free_ff    <= '0;
         held_ff    <= '0;
         used_ff    <= 1'b0;
      end else begin
         tok_ctl_ff <= tok_ctl_in;
         if (wr_ctl.en && (wr_idx == MY_IDX)) begin
            free_ff <= wr_free;
            held_ff <= wr_held;
            used_ff <= wr_ctl.used;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         tok_idx_ff  <= MY_IDX;
         tok_left_ff <= left;
         tok_held_ff <= used_ff ? held_ff : '0;
      end else begin
         tok_idx_ff  <= tok_in_idx;
         tok_left_ff <= tok_in_left;
         tok_held_ff <= tok_in_held;
      end
   end

   assign tok_out_ctl  = tok_ctl_ff;
   assign tok_out_idx  = tok_idx_ff;
   assign tok_out_left = tok_left_ff;
   assign tok_out_held = tok_held_ff;

endmodule

// ===== hw/rtl/partition_fit_allocator_unit.sv =====
// An allocate word launches a search word that walks the row of cells, one cell a cycle;
// its pick is then registered and moves through the done state into the output register.
// A load word goes straight to the done state; a stalled output holds a word there.
// One word is in work at a time: no new word is accepted until the last leaves the done state.
// A finished result waits in the output register while the next word is accepted.
// Synchronous active-high reset clears every partition, the next-fit pointer and the strategy.
module partition_fit_allocator_unit #(
   parameter int PARTITIONS = 8,
   parameter int SIZE_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [2:0]  req_partition_index,
   input  logic [15:0] req_amount,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_granted,
   output logic [2:0]  rsp_chosen_partition,
   output logic [15:0] rsp_space_after,
   output logic        rsp_partition_used,
   output logic [15:0] rsp_amount_held
);

   localparam int IW = $clog2(PARTITIONS);
   localparam int SW = SIZE_BITS;
   localparam logic [IW-1:0] LAST_IDX = IW'(PARTITIONS - 1);

   pfa_pkg::state_type     state_ff, state_in;
   pfa_pkg::strategy_type  strategy_ff;
   logic [IW-1:0]          ptr_ff, ptr_in;
   logic                   launch_ff;
   logic                   alloc_ff;
   logic [SW-1:0]          req_ff;
   logic                   pick_found_ff;
   logic [IW-1:0]          pick_idx_ff;
   logic [SW-1:0]          pick_free_ff;
   logic [SW-1:0]          pick_held_ff;
   logic                   pick_used_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_granted_ff;
   logic [2:0]             rsp_chosen_ff;
   logic [15:0]            rsp_space_ff;
   logic                   rsp_used_ff;
   logic [15:0]            rsp_held_ff;

   logic                   accept;
   logic                   done_fire;
   logic                   scan_end;
   logic [IW-1:0]          start;
   logic [SW+15:0]         amt_pad;
   logic [IW+2:0]          idx_in_pad;
   logic [IW+2:0]          idx_out_pad;
   logic [SW+15:0]         free_pad;
   logic [SW+15:0]         held_pad;
   logic                   idx_ok;
   logic [IW-1:0]          ptr_step;
   pfa_pkg::wr_ctl_type    wr_ctl;

   pfa_pkg::token_ctl_type tok_ctl  [0:PARTITIONS];
   logic [IW-1:0]          tok_idx  [0:PARTITIONS];
   logic [SW-1:0]          tok_left [0:PARTITIONS];
   logic [SW-1:0]          tok_held [0:PARTITIONS];
   logic [PARTITIONS-1:0]  tok_valids;

   assign accept      = req_valid && !req_stall;
   assign req_stall   = (state_ff != pfa_pkg::ST_IDLE);
   assign done_fire   = (state_ff == pfa_pkg::ST_DONE) && !(rsp_valid_ff && rsp_stall);
   assign scan_end    = (state_ff == pfa_pkg::ST_SCAN) && tok_ctl[PARTITIONS].valid;
   assign start       = (strategy_ff == pfa_pkg::STRAT_NEXT) ? ptr_ff : '0;
   assign amt_pad     = {{SW{1'b0}}, req_amount};
   assign idx_in_pad  = {{IW{1'b0}}, req_partition_index};
   assign idx_out_pad = {3'b000, pick_idx_ff};
   assign free_pad    = {16'h0000, pick_free_ff};
   assign held_pad    = {16'h0000, pick_held_ff};
   assign idx_ok      = ({29'd0, req_partition_index} < 32'(PARTITIONS));

   assign tok_ctl[0].valid = launch_ff;
   assign tok_ctl[0].found = 1'b0;
   assign tok_idx[0]       = '0;
   assign tok_left[0]      = '0;
   assign tok_held[0]      = '0;

   assign wr_ctl.en   = done_fire && pick_found_ff;
   assign wr_ctl.used = pick_used_ff;

   genvar g;
   generate
      for (g = 0; g < PARTITIONS; g++) begin : g_cell
         pfa_cell #(.IW(IW), .SW(SW), .MY(g)) u_cell (
            .clock       (clock),
            .reset       (reset),
            .strategy    (strategy_ff),
            .start       (start),
            .req         (req_ff),
            .tok_in_ctl  (tok_ctl[g]),
            .tok_in_idx  (tok_idx[g]),
            .tok_in_left (tok_left[g]),
            .tok_in_held (tok_held[g]),
            .wr_ctl      (wr_ctl),
            .wr_idx      (pick_idx_ff),
            .wr_free     (pick_free_ff),
            .wr_held     (pick_held_ff),
            .tok_out_ctl (tok_ctl[g+1]),
            .tok_out_idx (tok_idx[g+1]),
            .tok_out_left(tok_left[g+1]),
            .tok_out_held(tok_held[g+1])
         );
         assign tok_valids[g] = tok_ctl[g+1].valid;
      end
   endgenerate

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pfa_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_command == pfa_pkg::CMD_ALLOC) ? pfa_pkg::ST_SCAN
                                                                : pfa_pkg::ST_DONE;
            end
         end
         pfa_pkg::ST_SCAN: begin
            if (scan_end) begin
               state_in = pfa_pkg::ST_DONE;
            end
         end
         pfa_pkg::ST_DONE: begin
            if (done_fire) begin
               state_in = pfa_pkg::ST_IDLE;
            end
         end
         default: state_in = pfa_pkg::ST_IDLE;
      endcase
   end

   // The next-fit pointer takes a grant's index, zero for the last one; a valid load clears it.
   always_comb begin
      ptr_in   = ptr_ff;
      ptr_step = pick_found_ff ? pick_idx_ff : ptr_ff;
      if (done_fire) begin
         if (alloc_ff) begin
            if (strategy_ff == pfa_pkg::STRAT_NEXT) begin
               ptr_in = (ptr_step == LAST_IDX) ? '0 : ptr_step;
            end
         end else if (pick_found_ff) begin
            ptr_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfa_pkg::ST_IDLE;
         strategy_ff  <= pfa_pkg::STRAT_FIRST;
         ptr_ff       <= '0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ptr_ff    <= ptr_in;
         launch_ff <= accept && (req_command == pfa_pkg::CMD_ALLOC);
         if (csr_wr_en) begin
            strategy_ff <= pfa_pkg::strategy_type'(csr_wr_data);
         end
         if (done_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         alloc_ff      <= (req_command == pfa_pkg::CMD_ALLOC);
         req_ff        <= amt_pad[SW-1:0];
         pick_found_ff <= idx_ok;
         pick_idx_ff   <= idx_in_pad[IW-1:0];
         pick_free_ff  <= amt_pad[SW-1:0];
         pick_held_ff  <= '0;
         pick_used_ff  <= 1'b0;
      end else if (scan_end) begin
         pick_found_ff <= tok_ctl[PARTITIONS].found;
         pick_idx_ff   <= tok_idx[PARTITIONS];
         pick_free_ff  <= tok_left[PARTITIONS];
         pick_held_ff  <= tok_held[PARTITIONS] + req_ff;
         pick_used_ff  <= 1'b1;
      end
      if (done_fire) begin
         rsp_granted_ff <= pick_found_ff;
         rsp_chosen_ff  <= pick_found_ff ? idx_out_pad[2:0] : 3'b000;
         rsp_space_ff   <= pick_found_ff ? free_pad[15:0] : 16'h0000;
         rsp_used_ff    <= pick_found_ff && pick_used_ff;
         rsp_held_ff    <= (pick_found_ff && pick_used_ff) ? held_pad[15:0] : 16'h0000;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_granted          = rsp_granted_ff;
   assign rsp_chosen_partition = rsp_chosen_ff;
   assign rsp_space_after      = rsp_space_ff;
   assign rsp_partition_used   = rsp_used_ff;
   assign rsp_amount_held      = rsp_held_ff;

`ifndef SYNTHESIS
   a_one_word_in_row: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valids))
      else $error("More than one search word is travelling along the partition row.");

   a_word_leaves_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok_ctl[PARTITIONS].valid |-> (state_ff == pfa_pkg::ST_SCAN))
      else $error("A search word left the row outside a scan.");

   a_done_gives_result: assert property (@(posedge clock) disable iff (reset)
      done_fire |=> (rsp_valid && (state_ff == pfa_pkg::ST_IDLE)))
      else $error("A finished word did not reach the output register.");

   a_refused_is_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_granted) |->
         (rsp_chosen_partition == 3'b000 && rsp_space_after == 16'h0000 &&
          !rsp_partition_used && rsp_amount_held == 16'h0000))
      else $error("A refused result carries non-zero fields.");

   a_held_needs_used: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_amount_held != 16'h0000)) |-> rsp_partition_used)
      else $error("A held amount is reported for an unused partition.");
`endif

endmodule
